// File: rtl/mbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed coefficients of the Mueller-Brown energy pipeline.
package mbe_pkg;

    localparam int NLANE = 4;   // one lane per exponential term
    localparam int NTAY  = 11;  // series steps for k = 2..12

    // Centers in units of one half, exact in any coordinate format
    localparam logic signed [2:0] CXH [0:NLANE-1] = '{3'sd2, 3'sd0, -3'sd1, -3'sd2};
    localparam logic signed [2:0] CYH [0:NLANE-1] = '{3'sd0, 3'sd1, 3'sd3, 3'sd2};

    // Quadratic form coefficients, Q.16
    localparam logic signed [20:0] QA [0:NLANE-1] =
        '{-21'sd65536, -21'sd65536, -21'sd425984, 21'sd45875};
    localparam logic signed [20:0] QB [0:NLANE-1] =
        '{21'sd0, 21'sd0, 21'sd720896, 21'sd39322};
    localparam logic signed [20:0] QC [0:NLANE-1] =
        '{-21'sd655360, -21'sd655360, -21'sd425984, 21'sd45875};

    // Half weights: 0.1 * A_k * 2
    localparam logic signed [6:0] WT [0:NLANE-1] = '{-7'sd40, -7'sd20, -7'sd34, 7'sd3};

    // Exponential argument window, Q.16
    localparam logic signed [38:0] ARG_LOW  = -39'sd1572864;
    localparam logic signed [38:0] ARG_HIGH = 39'sd1048576;

    localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    // floor(2^36 / k) for the series divisors that are not powers of two
    localparam int RCP_SH = 36;
    localparam logic [34:0] RCP [0:12] = '{
        35'd0, 35'd0, 35'd0, 35'd22906492245, 35'd0, 35'd13743895347,
        35'd11453246122, 35'd9817068105, 35'd0, 35'd7635497415,
        35'd6871947673, 35'd6247225157, 35'd5726623061};

    localparam logic signed [65:0] E_MAX = 66'sd8388607;
    localparam logic signed [65:0] E_MIN = -66'sd8388608;

    // Per-lane flags that ride along with the series
    typedef struct packed {
        logic signed [6:0] n;    // integer part of q*log2(e)
        logic              ok;   // argument inside the window
        logic              big;  // argument above the window
    } t_side;

    // One series stage
    typedef struct packed {
        logic [31:0] r;      // reduced argument, Q.32
        logic [33:0] sum;    // running series sum, Q.32
        logic [31:0] term;   // current term or partial result
        logic [31:0] aux;    // undivided product
        t_side       side;
    } t_tay;

endpackage

// File: rtl/mbe_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for coordinate and energy beats.
interface mbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface mbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] energy;
    logic               saturated;
    modport source (output valid, output energy, output saturated, input ready);
    modport sink   (input valid, input energy, input saturated, output ready);
endinterface

// File: rtl/mueller_brown_energy.sv
`timescale 1ns / 1ps
// Pipelined Mueller-Brown potential evaluator, one coordinate pair per cycle while the output is not stalled.
//
//  channel | dir | payload                          | beat taken when
//  i_in    | in  | x_coord, y_coord (Q3.12 signed)  | valid && ready
//  o_out   | out | energy (Q15.8 signed), saturated | valid && ready
//
//  One beat enters per cycle unless the output stalls; results leave in the order of their beats.
//  The depth is set by the exp series: eleven multiply/divide steps of
//  three stages each, shared by nothing, one series per center.
//  Reset clears the stage valid bits only.
//  A stalled output holds the whole pipeline; no beat is lost or repeated.
module mueller_brown_energy
    import mbe_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = 12,
    parameter int ENERGY_FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbe_in_if.sink       i_in,
    mbe_out_if.source    o_out
);

    localparam int SQ_SH = 2 * COORD_FRAC_BITS - 16;
    localparam int HALF  = 1 << (COORD_FRAC_BITS - 1);
    localparam int NSTG  = 6 + 3 * NTAY + 4;
    localparam logic signed [65:0] RND = 66'sd1 <<< (32 - ENERGY_FRAC_BITS);

    typedef enum logic [1:0] {BIG_NONE, BIG_POS, BIG_NEG} t_big;

    logic [NSTG-1:0]   r_vld;
    logic              w_en;
    logic signed [65:0] r_wp   [NLANE];
    logic               r_wbig [NLANE];
    logic signed [65:0] r_acc;
    t_big               r_bcode;
    logic signed [23:0] r_energy;
    logic               r_sat;

    // Global advance: move when the output stage is free or being drained
    assign w_en        = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready  = w_en;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // One lane per center
    for (genvar gk = 0; gk < NLANE; gk++) begin : g_lane
        localparam int CXV = int'(CXH[gk]) * HALF;
        localparam int CYV = int'(CYH[gk]) * HALF;
        localparam logic signed [23:0] CX = 24'(CXV);
        localparam logic signed [23:0] CY = 24'(CYV);

        logic signed [23:0] r_dx, r_dy;
        logic signed [31:0] r_sxx, r_sxy, r_syy;
        logic signed [52:0] r_pa, r_pb, r_pc;
        logic signed [21:0] r_qn;
        logic               r_ok, r_big;
        t_side              r_side;
        logic [31:0]        r_f;
        t_tay               r_s6;
        t_tay               r_ta [NTAY];
        t_tay               r_tb [NTAY];
        t_tay               r_tc [NTAY];
        logic [56:0]        r_e;
        logic               r_ebig;

        logic signed [47:0] n_xx, n_xy, n_yy;
        logic signed [54:0] n_qs;
        logic signed [38:0] n_q;
        logic signed [51:0] n_uf;
        logic signed [38:0] n_u;
        logic [63:0]        n_rp;
        logic [6:0]         n_rsh;
        logic [56:0]        n_e;

        assign n_xx = r_dx * r_dx;
        assign n_xy = r_dx * r_dy;
        assign n_yy = r_dy * r_dy;
        assign n_qs = 55'(r_pa) + 55'(r_pb) + 55'(r_pc);
        assign n_q  = 39'(n_qs >>> 16);
        assign n_uf = r_qn * $signed({1'b0, LOG2E_Q28});
        assign n_u  = 39'(n_uf >>> 12);
        assign n_rp = 64'(r_f) * 64'(LN2_Q32);

        // Front: offsets, squares, quadratic form, log2 scaling, reduction
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dx  <= 24'(i_in.x_coord) - CX;
                r_dy  <= 24'(i_in.y_coord) - CY;
                r_sxx <= 32'(n_xx >>> SQ_SH);
                r_sxy <= 32'(n_xy >>> SQ_SH);
                r_syy <= 32'(n_yy >>> SQ_SH);
                r_pa  <= QA[gk] * r_sxx;
                r_pb  <= QB[gk] * r_sxy;
                r_pc  <= QC[gk] * r_syy;
                r_big <= n_q > ARG_HIGH;
                r_ok  <= (n_q >= ARG_LOW) && !(n_q > ARG_HIGH);
                r_qn  <= ((n_q >= ARG_LOW) && !(n_q > ARG_HIGH)) ?
                         $signed(n_q[21:0]) : 22'sd0;
                r_side <= '{n: $signed(n_u[38:32]), ok: r_ok, big: r_big};
                r_f   <= n_u[31:0];
                r_s6  <= '{r: n_rp[63:32],
                           sum: 34'h1_0000_0000 + 34'(n_rp[63:32]),
                           term: n_rp[63:32],
                           aux: '0,
                           side: r_side};
            end
        end

        // Series steps k = 2..12: multiply, estimate quotient, correct
        for (genvar gj = 0; gj < NTAY; gj++) begin : g_tay
            localparam int  K   = gj + 2;
            localparam bit  P2  = (K == 2) || (K == 4) || (K == 8);
            localparam int  SH  = $clog2(K);

            t_tay        w_tin;
            t_tay        n_ta, n_tb, n_tc;
            logic [63:0] n_wp;
            logic [31:0] n_qe;
            logic [31:0] n_qf;
            logic [35:0] n_qk;
            logic [35:0] n_rem;

            if (gj == 0) begin : g_first
                assign w_tin = r_s6;
            end else begin : g_next
                assign w_tin = r_tc[gj-1];
            end

            assign n_wp = 64'(w_tin.term) * 64'(w_tin.r);

            if (P2) begin : g_shift
                assign n_qe = r_ta[gj].term >> SH;
            end else begin : g_recip
                logic [66:0] n_qp;
                assign n_qp = 67'(r_ta[gj].term) * 67'(RCP[K]);
                assign n_qe = 32'(n_qp >> RCP_SH);
            end

            assign n_qk  = 36'(r_tb[gj].term) * 36'(K);
            assign n_rem = 36'(r_tb[gj].aux) - n_qk;
            assign n_qf  = (n_rem >= 36'(K)) ? r_tb[gj].term + 32'd1 : r_tb[gj].term;

            // Next contents of the three stages of this step
            always_comb begin
                n_ta      = w_tin;
                n_ta.term = n_wp[63:32];
                n_tb      = r_ta[gj];
                n_tb.term = n_qe;
                n_tb.aux  = r_ta[gj].term;
                n_tc      = r_tb[gj];
                n_tc.term = n_qf;
                n_tc.sum  = r_tb[gj].sum + 34'(n_qf);
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_ta[gj] <= n_ta;
                    r_tb[gj] <= n_tb;
                    r_tc[gj] <= n_tc;
                end
            end
        end

        // Scale by 2^n and weight
        assign n_rsh = 7'(-r_tc[NTAY-1].side.n);
        always_comb begin
            if (!r_tc[NTAY-1].side.ok) begin
                n_e = '0;
            end else if (!r_tc[NTAY-1].side.n[6]) begin
                n_e = 57'(r_tc[NTAY-1].sum) << r_tc[NTAY-1].side.n[5:0];
            end else begin
                n_e = 57'(r_tc[NTAY-1].sum >> n_rsh);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_e         <= n_e;
                r_ebig      <= r_tc[NTAY-1].side.big;
                r_wp[gk]    <= 66'(WT[gk]) * $signed({9'b0, r_e});
                r_wbig[gk]  <= r_ebig;
            end
        end
    end

    // Sum of weighted terms and overflow resolution; later lanes win
    logic signed [65:0] n_acc;
    t_big               n_bcode;
    logic signed [65:0] n_sh;

    always_comb begin
        n_acc   = RND;
        n_bcode = BIG_NONE;
        for (int i = 0; i < NLANE; i++) begin
            n_acc = n_acc + r_wp[i];
            if (r_wbig[i]) begin
                n_bcode = (WT[i] > 7'sd0) ? BIG_POS : BIG_NEG;
            end
        end
    end

    assign n_sh = r_acc >>> (33 - ENERGY_FRAC_BITS);

    // Rounding, saturation and output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc   <= n_acc;
            r_bcode <= n_bcode;
            unique case (r_bcode)
                BIG_POS: begin
                    r_energy <= 24'(E_MAX);
                    r_sat    <= 1'b1;
                end
                BIG_NEG: begin
                    r_energy <= 24'(E_MIN);
                    r_sat    <= 1'b1;
                end
                default: begin
                    if (n_sh > E_MAX) begin
                        r_energy <= 24'(E_MAX);
                        r_sat    <= 1'b1;
                    end else if (n_sh < E_MIN) begin
                        r_energy <= 24'(E_MIN);
                        r_sat    <= 1'b1;
                    end else begin
                        r_energy <= 24'(n_sh);
                        r_sat    <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_out.valid     = r_vld[NSTG-1];
    assign o_out.energy    = r_energy;
    assign o_out.saturated = r_sat;

    // Checks
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |->
            o_out.energy == 24'sh7FFFFF || o_out.energy == 24'sh800000)
        else $error("saturated result not at a range limit");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input refused with empty output stage");

endmodule
